// ===== design/multilevel_bucket_hash_set_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef MULTILEVEL_BUCKET_HASH_SET_DEFINES_SVH
`define MULTILEVEL_BUCKET_HASH_SET_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MBHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MBHS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mbhs_pkg.sv =====
package mbhs_pkg;

	localparam int INIT_BUCKETS = 256;
	localparam int NUM_LEVELS   = 4;
	localparam int ROW_SLOTS    = 15;

	localparam int TOTAL_ROWS = INIT_BUCKETS * ((1 << NUM_LEVELS) - 1);
	localparam int ROW_W      = $clog2(TOTAL_ROWS);
	localparam int LV_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int SLOT_W     = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
	localparam int CNT_W      = 4;

	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic CFG_HASH_SEED    = 1'b0;
	localparam logic CFG_MAX_ELEMENTS = 1'b1;

	localparam logic [1:0] ST_ABSENT  = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [4:0] MAX_ELEMENTS_RST = 5'd8;

	localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2   = 32'h1b873593;
	localparam logic [31:0] MM_ADD  = 32'he6546b64;
	localparam logic [31:0] MM_LEN  = 32'd4;
	localparam logic [31:0] MM_F1   = 32'h85ebca6b;
	localparam logic [31:0] MM_F2   = 32'hc2b2ae35;

	typedef struct packed {
		logic        operation;
		logic [31:0] key;
		logic [31:0] hash;
	} item_t;

	// first global row of a level
	function automatic logic [ROW_W-1:0] row_base(input logic [LV_W-1:0] lv);
		return ROW_W'(INIT_BUCKETS * ((1 << lv) - 1));
	endfunction

	// bucket index mask of a level (sizes are powers of two)
	function automatic logic [ROW_W-1:0] row_mask(input logic [LV_W-1:0] lv);
		return ROW_W'((INIT_BUCKETS << lv) - 1);
	endfunction

endpackage

// ===== design/mbhs_ifs.sv =====
interface mbhs_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface mbhs_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [1:0] level;

	modport source (output valid, output status, output level, input ready);
	modport sink   (input valid, input status, input level, output ready);
endinterface

// ===== design/mbhs_front.sv =====
module mbhs_front (
	input  logic          clk,
	input  logic          arst_n,
	mbhs_req_if.sink      req,
	input  logic [31:0]   hash_seed,
	output mbhs_pkg::item_t push_item,
	output logic          push,
	input  logic          full
);
	import mbhs_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_M2, F_M3, F_M4, F_M5, F_PUSH} fstate_t;

	fstate_t     state_q;
	logic        op_q;
	logic [31:0] key_q;
	logic [31:0] x_q;
	logic [31:0] h3;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	always_comb begin
		h3 = (rotl(hash_seed ^ x_q, 13) * 32'd5 + MM_ADD) ^ MM_LEN;
		h3 = h3 ^ (h3 >> 16);
	end

	assign req.ready = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign push_item = '{operation: op_q, key: key_q, hash: x_q ^ (x_q >> 16)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						state_q <= F_M2;
					end
				end
				F_M2:   state_q <= F_M3;
				F_M3:   state_q <= F_M4;
				F_M4:   state_q <= F_M5;
				F_M5:   state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// one multiply per cycle through the mixing steps
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.valid) begin
					op_q  <= req.operation;
					key_q <= req.key;
					x_q   <= req.key * MM_C1;
				end
			end
			F_M2:    x_q <= rotl(x_q, 15) * MM_C2;
			F_M3:    x_q <= h3;
			F_M4:    x_q <= x_q * MM_F1;
			F_M5:    x_q <= (x_q ^ (x_q >> 13)) * MM_F2;
			default: x_q <= x_q;
		endcase
	end
endmodule

// ===== design/mbhs_queue.sv =====
module mbhs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbhs_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output mbhs_pkg::item_t pop_item,
	output logic            empty
);
	import mbhs_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end
endmodule

// ===== design/mbhs_back.sv =====
module mbhs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [4:0]      max_elements,
	input  mbhs_pkg::item_t pop_item,
	input  logic            empty,
	output logic            pop,
	mbhs_rsp_if.source      rsp
);
	import mbhs_pkg::*;

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CMP} bstate_t;

	bstate_t          state_q;
	logic [ROW_W-1:0] clr_q;
	item_t            cur_q;
	logic [LV_W-1:0]  level_q;
	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic [1:0]       level_out_q;

	logic [31:0]      key_mem [ROW_SLOTS][TOTAL_ROWS];
	logic [CNT_W-1:0] cnt_mem [TOTAL_ROWS];
	logic [31:0]      slot_rd [ROW_SLOTS];
	logic [CNT_W-1:0] cnt_rd;

	logic [ROW_W-1:0] row_addr;
	logic [CNT_W-1:0] limit;
	logic             match;
	logic             last;
	logic             done;
	logic             store;
	logic             proceed;
	logic [1:0]       res_status;
	logic [1:0]       res_level;
	logic             key_we;
	logic             cnt_we;
	logic [ROW_W-1:0] cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;

	assign row_addr = row_base(level_q) + (cur_q.hash[ROW_W-1:0] & row_mask(level_q));
	assign last     = (level_q == LV_W'(NUM_LEVELS - 1));
	assign pop      = (state_q == B_IDLE) && !empty;
	assign proceed  = !rsp_valid_q || rsp.ready;

	always_comb begin
		if (max_elements < 5'd2) begin
			limit = '0;
		end else if (max_elements > 5'(ROW_SLOTS + 1)) begin
			limit = CNT_W'(ROW_SLOTS);
		end else begin
			limit = CNT_W'(max_elements - 5'd1);
		end
	end

	// only slots below the fill count are live
	always_comb begin
		match = 1'b0;
		for (int s = 0; s < ROW_SLOTS; s++) begin
			if ((CNT_W'(s) < cnt_rd) && (slot_rd[s] == cur_q.key)) begin
				match = 1'b1;
			end
		end
	end

	always_comb begin
		done       = 1'b0;
		store      = 1'b0;
		res_status = ST_ABSENT;
		res_level  = 2'(level_q);
		if (match) begin
			done       = 1'b1;
			res_status = ST_PRESENT;
		end else if (cur_q.operation == OP_INSERT && cnt_rd < limit) begin
			done       = 1'b1;
			store      = 1'b1;
		end else if (last) begin
			done       = 1'b1;
			res_status = (cur_q.operation == OP_INSERT) ? ST_FULL : ST_ABSENT;
			res_level  = 2'd0;
		end
	end

	assign key_we    = (state_q == B_CMP) && done && store && proceed;
	assign cnt_we    = (state_q == B_CLEAR) || key_we;
	assign cnt_waddr = (state_q == B_CLEAR) ? clr_q : row_addr;
	assign cnt_wdata = (state_q == B_CLEAR) ? '0 : cnt_rd + CNT_W'(1);

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.level  = level_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			level_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(TOTAL_ROWS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!empty) begin
						level_q <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_CMP;
				B_CMP: begin
					if (done) begin
						if (proceed) begin
							rsp_valid_q <= 1'b1;
							state_q     <= B_IDLE;
						end
					end else begin
						level_q <= level_q + LV_W'(1);
						state_q <= B_READ;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_item;
		end
		if (state_q == B_CMP && done && proceed) begin
			status_q    <= res_status;
			level_out_q <= res_level;
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < ROW_SLOTS; s++) begin
			if (key_we && cnt_rd[SLOT_W-1:0] == SLOT_W'(s)) begin
				key_mem[s][row_addr] <= cur_q.key;
			end
			slot_rd[s] <= key_mem[s][row_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd <= cnt_mem[row_addr];
	end
endmodule

// ===== design/multilevel_bucket_hash_set.sv =====
// Flow: the front hashes a request through its mixing states and pushes the item into the
// queue; the back end reads and compares one level at a time and registers the response.
// The front takes no new request until it has pushed the last one, and it waits while the
// queue is full; each further level searched takes another read and compare in the back end.
// Reset: config returns to seed 0 and max_elements 8; the back end then clears the
// 3840 row counts, one per cycle, before it serves its first transaction.
module multilevel_bucket_hash_set (
	input  logic        clk,
	input  logic        arst_n,
	mbhs_req_if.sink    req,
	mbhs_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import mbhs_pkg::*;

	logic [31:0] hash_seed_q;
	logic [4:0]  max_elements_q;
	item_t       push_item;
	item_t       pop_item;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q    <= '0;
			max_elements_q <= MAX_ELEMENTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HASH_SEED:    hash_seed_q    <= cfg_data;
				CFG_MAX_ELEMENTS: max_elements_q <= cfg_data[4:0];
				default:          hash_seed_q    <= hash_seed_q;
			endcase
		end
	end

	mbhs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.hash_seed (hash_seed_q),
		.push_item (push_item),
		.push      (push),
		.full      (full)
	);

	mbhs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	mbhs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_elements (max_elements_q),
		.pop_item     (pop_item),
		.empty        (empty),
		.pop          (pop),
		.rsp          (rsp)
	);
endmodule

// ===== design/mbhs_checker.sv =====
`include "multilevel_bucket_hash_set_defines.svh"

module mbhs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [1:0] rsp_level
);
	import mbhs_pkg::*;

	// a request busies the hash unit, so ready is low once it is taken
	`MBHS_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after request")
	`MBHS_ASSERT_IMP(a_full_level0, rsp_valid && rsp_status == ST_FULL, rsp_level == 2'd0, "full with level")
	`MBHS_ASSERT_IMP(a_no_rsp_at_reset, $rose(arst_n), !rsp_valid, "response right after reset")
	`MBHS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response dropped")
endmodule

bind multilevel_bucket_hash_set mbhs_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_level  (rsp.level)
);
